[hdl/pba_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types, request codes and helpers for the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

	localparam int unsigned PAGE_COUNT_DEF = 4096;
	localparam int unsigned BITS_PER_WORD  = 8;
	localparam int unsigned WORD_BIT_W     = 3;
	localparam logic [BITS_PER_WORD-1:0] WORD_ONES = 8'hFF;

	localparam logic [1:0] MODE_ALLOC      = 2'd0;
	localparam logic [1:0] MODE_FREE       = 2'd1;
	localparam logic [1:0] MODE_SET_USABLE = 2'd2;

	// One memory word covers eight pages of both bitmaps.
	typedef struct packed {
		logic [BITS_PER_WORD-1:0] alloc;
		logic [BITS_PER_WORD-1:0] usable;
	} map_word_t;

	typedef struct packed {
		logic        ok;
		logic [11:0] granted_page;
		logic [12:0] allocated_count;
		logic [12:0] usable_count;
	} result_t;

	function automatic logic [WORD_BIT_W-1:0] lowest_bit(input logic [BITS_PER_WORD-1:0] v);
		logic [WORD_BIT_W-1:0] idx;
		idx = '0;
		for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = WORD_BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

[hdl/page_bitmap_allocator_top.sv]
`default_nettype none
// Page bitmap allocator with next-fit allocation. After reset the block runs a
// clearing pass over the bitmap memory, one word of eight pages per cycle,
// and holds req_stall high until it is done. Free and set-usable of a page in
// range read its bitmap word and update it in the read-modify-write state
// and then offer the result word to the output register. Allocate answers
// without a scan when the allocated and usable counts are equal; otherwise the
// scan examines one bitmap word per cycle through the read port of the bitmap
// memory, starting after the last page handed out. A stalled output register
// holds the result word in the sequencer, and the next request is accepted in
// the cycle after the result word moves into the output register. A finished
// word waits in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
// page_bitmap_allocator_top
// Request and response channels, output register and checks around the
// bitmap sequencer.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_top import pba_pkg::*; #(
	parameter int unsigned PAGE_COUNT = PAGE_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [11:0] page,
	input  wire logic        usable_flag,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic             ok,
	output logic [11:0]      granted_page,
	output logic [12:0]      allocated_count,
	output logic [12:0]      usable_count
);

	logic    res_valid;
	result_t res;
	logic    res_take;
	logic    rsp_valid_q;
	result_t rsp_q;

	pba_seq #(
		.PAGE_COUNT(PAGE_COUNT)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.mode       (mode),
		.page       (page),
		.usable_flag(usable_flag),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (res_take)
	);

	// A new word moves in when the output register is empty or being drained.
	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign ok              = rsp_q.ok;
	assign granted_page    = rsp_q.granted_page;
	assign allocated_count = rsp_q.allocated_count;
	assign usable_count    = rsp_q.usable_count;

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |-> !res_take)
		else $error("result word moved into a stalled output register");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |-> !res_valid)
		else $error("request accepted while a result is pending in the sequencer");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("second request accepted while one is in progress");
`endif

endmodule
`default_nettype wire

[hdl/pba_map_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pba_map_ram
// Bitmap memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pba_map_ram import pba_pkg::*; #(
	parameter int unsigned DEPTH = 512,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire map_word_t     wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output map_word_t          rdata
);

	map_word_t mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[hdl/pba_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pba_seq
// Request sequencer: clearing pass, read-modify-write of one bitmap word for
// free and set-usable, and the word-by-word next-fit scan for allocate.
// ----------------------------------------------------------------------------
module pba_seq import pba_pkg::*; #(
	parameter int unsigned PAGE_COUNT = PAGE_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [11:0] page,
	input  wire logic        usable_flag,
	output logic             res_valid,
	output result_t          res,
	input  wire logic        res_take
);

	localparam int unsigned PW     = $clog2(PAGE_COUNT);
	localparam int unsigned NWORDS = (PAGE_COUNT + BITS_PER_WORD - 1) / BITS_PER_WORD;
	localparam int unsigned WAW    = $clog2(NWORDS);
	localparam int unsigned CW     = $clog2(PAGE_COUNT + 1);
	localparam int unsigned VW     = $clog2(NWORDS + 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_RMW   = 3'd3;
	localparam logic [2:0] ST_RESP  = 3'd4;

	logic [2:0]     state_q, state_d;
	logic [WAW-1:0] clr_q, clr_d;
	logic [1:0]     mode_q, mode_d;
	logic [PW-1:0]  page_q, page_d;
	logic           flag_q, flag_d;
	logic [PW-1:0]  cursor_q, cursor_d;
	logic [WAW-1:0] word_s1, word_d;
	logic [VW-1:0]  vis_q, vis_d;
	logic [CW-1:0]  alloc_tot_q, alloc_tot_d;
	logic [CW-1:0]  usable_tot_q, usable_tot_d;
	result_t        res_q, res_d;

	logic           mem_we;
	logic [WAW-1:0] mem_waddr;
	map_word_t      mem_wdata;
	logic           mem_re;
	logic [WAW-1:0] mem_raddr;
	map_word_t      mem_rdata;

	logic [PW-1:0]            page_idx;
	logic                     page_in_range;
	logic [PW-1:0]            cur_next;
	logic [WAW-1:0]           start_word;
	logic [WORD_BIT_W-1:0]    start_bit;
	logic [WAW-1:0]           cur_word;
	logic [WORD_BIT_W-1:0]    cur_bit;
	logic [WAW-1:0]           word_inc;
	logic [BITS_PER_WORD-1:0] lo_mask;
	logic [BITS_PER_WORD-1:0] vis_mask;
	logic [BITS_PER_WORD-1:0] cand;
	logic                     found;
	logic [WORD_BIT_W-1:0]    pick;
	logic [PW-1:0]            pick_page;
	logic [WAW-1:0]           pword;
	logic [WORD_BIT_W-1:0]    pbit;

	pba_map_ram #(
		.DEPTH(NWORDS),
		.AW   (WAW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign page_idx      = PW'(page);
	assign page_in_range = 32'(page) < 32'(PAGE_COUNT);
	assign cur_next      = (cursor_q == PW'(PAGE_COUNT - 1)) ? '0 : cursor_q + 1'b1;
	assign start_word    = WAW'(cur_next >> WORD_BIT_W);
	assign start_bit     = cur_next[WORD_BIT_W-1:0];
	assign cur_word      = WAW'(cursor_q >> WORD_BIT_W);
	assign cur_bit       = cursor_q[WORD_BIT_W-1:0];
	assign word_inc      = (word_s1 == WAW'(NWORDS - 1)) ? '0 : word_s1 + 1'b1;
	assign pword         = WAW'(page_q >> WORD_BIT_W);
	assign pbit          = page_q[WORD_BIT_W-1:0];

	// The first visit covers the start word from cursor+1 upward; the final
	// visit comes back to that word for the pages below cursor+1.
	always_comb begin
		lo_mask = WORD_ONES << start_bit;
		if (vis_q == '0) begin
			vis_mask = lo_mask;
		end else if (vis_q == VW'(NWORDS)) begin
			vis_mask = ~lo_mask;
		end else begin
			vis_mask = WORD_ONES;
		end
		if (word_s1 == cur_word) begin
			vis_mask = vis_mask & ~(BITS_PER_WORD'(1) << cur_bit);
		end
		cand      = mem_rdata.usable & ~mem_rdata.alloc & vis_mask;
		found     = |cand;
		pick      = lowest_bit(cand);
		pick_page = PW'({word_s1, pick});
	end

	always_comb begin
		state_d      = state_q;
		clr_d        = clr_q;
		mode_d       = mode_q;
		page_d       = page_q;
		flag_d       = flag_q;
		cursor_d     = cursor_q;
		word_d       = word_s1;
		vis_d        = vis_q;
		alloc_tot_d  = alloc_tot_q;
		usable_tot_d = usable_tot_q;
		res_d        = res_q;
		mem_we       = 1'b0;
		mem_waddr    = clr_q;
		mem_wdata    = '0;
		mem_re       = 1'b0;
		mem_raddr    = start_word;

		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				clr_d  = clr_q + 1'b1;
				if (clr_q == WAW'(NWORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					mode_d             = mode;
					page_d             = page_idx;
					flag_d             = usable_flag;
					res_d.ok           = 1'b0;
					res_d.granted_page = '0;
					case (mode)
						MODE_ALLOC: begin
							if (alloc_tot_q == usable_tot_q) begin
								state_d = ST_RESP;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = start_word;
								word_d    = start_word;
								vis_d     = '0;
								state_d   = ST_SCAN;
							end
						end
						MODE_FREE, MODE_SET_USABLE: begin
							if (page_in_range) begin
								mem_re    = 1'b1;
								mem_raddr = WAW'(page_idx >> WORD_BIT_W);
								state_d   = ST_RMW;
							end else begin
								state_d = ST_RESP;
							end
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end
			ST_SCAN: begin
				// Keep one word read ahead of the word being examined.
				mem_re    = 1'b1;
				mem_raddr = word_inc;
				word_d    = word_inc;
				vis_d     = vis_q + 1'b1;
				if (found) begin
					mem_we                   = 1'b1;
					mem_waddr                = word_s1;
					mem_wdata.usable         = mem_rdata.usable;
					mem_wdata.alloc          = mem_rdata.alloc | (BITS_PER_WORD'(1) << pick);
					cursor_d                 = pick_page;
					alloc_tot_d              = alloc_tot_q + 1'b1;
					res_d.ok                 = 1'b1;
					res_d.granted_page       = 12'(pick_page);
					state_d                  = ST_RESP;
				end else if (vis_q == VW'(NWORDS)) begin
					state_d = ST_RESP;
				end
			end
			ST_RMW: begin
				mem_waddr = pword;
				mem_wdata = mem_rdata;
				if (mode_q == MODE_FREE) begin
					if (mem_rdata.alloc[pbit] && mem_rdata.usable[pbit]) begin
						mem_we                = 1'b1;
						mem_wdata.alloc[pbit] = 1'b0;
						res_d.ok              = 1'b1;
						if (alloc_tot_q != '0) begin
							alloc_tot_d = alloc_tot_q - 1'b1;
						end
					end
				end else begin
					mem_we                 = 1'b1;
					mem_wdata.usable[pbit] = flag_q;
					res_d.ok               = 1'b1;
					if (flag_q && !mem_rdata.usable[pbit]) begin
						usable_tot_d = usable_tot_q + 1'b1;
					end else if (!flag_q && mem_rdata.usable[pbit] && usable_tot_q != '0) begin
						usable_tot_d = usable_tot_q - 1'b1;
					end
				end
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (state_d == ST_RESP && state_q != ST_RESP) begin
			res_d.allocated_count = 13'(alloc_tot_d);
			res_d.usable_count    = 13'(usable_tot_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			cursor_q     <= '0;
			alloc_tot_q  <= '0;
			usable_tot_q <= '0;
		end else begin
			state_q      <= state_d;
			clr_q        <= clr_d;
			cursor_q     <= cursor_d;
			alloc_tot_q  <= alloc_tot_d;
			usable_tot_q <= usable_tot_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q  <= mode_d;
		page_q  <= page_d;
		flag_q  <= flag_d;
		word_s1 <= word_d;
		vis_q   <= vis_d;
		res_q   <= res_d;
	end

	assign req_stall = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_RESP);
	assign res       = res_q;

endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the page bitmap allocator. A behavioral copy of
// both bitmaps, the cursor and the live counts predicts every reply word,
// which is compared field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb import pba_pkg::*;;

	localparam int unsigned PAGE_COUNT     = PAGE_COUNT_DEF;
	localparam logic [1:0]  MODE_UNUSED    = 2'd3;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          SETTLE_CYCLES  = 600;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  mode = MODE_ALLOC;
	logic [11:0] page = '0;
	logic        usable_flag = 1'b0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic        ok;
	logic [11:0] granted_page;
	logic [12:0] allocated_count;
	logic [12:0] usable_count;

	// Behavioral copy of the allocator state.
	bit          alloc_bits[PAGE_COUNT];
	bit          usable_bits[PAGE_COUNT];
	logic [11:0] last_grant = '0;
	int          pages_held = 0;
	int          pages_usable = 0;
	logic [11:0] held_pages[$];

	result_t     pending_replies[$];
	result_t     want;
	int          fail_count = 0;
	int          quiet_cycles = 0;

	bit          send_idle_on = 1'b1;
	bit          recv_idle_on = 1'b1;
	int          hold_request = 0;
	int          hold_left = 0;
	int          stall_left = 0;

	page_bitmap_allocator_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.mode            (mode),
		.page            (page),
		.usable_flag     (usable_flag),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.ok              (ok),
		.granted_page    (granted_page),
		.allocated_count (allocated_count),
		.usable_count    (usable_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic result_t serve_request(input logic [1:0] m, input logic [11:0] pg,
			input logic fl);
		result_t     r;
		logic [11:0] scan;
		r = '0;
		case (m)
		MODE_ALLOC: begin
			// Next-fit scan that starts after the cursor and never looks at it.
			if (pages_held != pages_usable) begin
				scan = last_grant + 12'd1;
				while (scan != last_grant && !r.ok) begin
					if (usable_bits[scan] && !alloc_bits[scan]) begin
						alloc_bits[scan] = 1'b1;
						last_grant = scan;
						pages_held++;
						held_pages.push_back(scan);
						r.ok = 1'b1;
						r.granted_page = scan;
					end
					scan++;
				end
			end
		end
		MODE_FREE: begin
			if (int'(pg) < PAGE_COUNT && alloc_bits[pg] && usable_bits[pg]) begin
				alloc_bits[pg] = 1'b0;
				if (pages_held > 0)
					pages_held--;
				foreach (held_pages[i]) begin
					if (held_pages[i] == pg) begin
						held_pages.delete(i);
						break;
					end
				end
				r.ok = 1'b1;
			end
		end
		MODE_SET_USABLE: begin
			if (int'(pg) < PAGE_COUNT) begin
				if (fl && !usable_bits[pg])
					pages_usable++;
				else if (!fl && usable_bits[pg] && pages_usable > 0)
					pages_usable--;
				usable_bits[pg] = fl;
				r.ok = 1'b1;
			end
		end
		default: begin
		end
		endcase
		r.allocated_count = 13'(pages_held);
		r.usable_count = 13'(pages_usable);
		return r;
	endfunction

	// Presents one request word and records its predicted reply on acceptance.
	task automatic send_request(input logic [1:0] m, input logic [11:0] pg, input logic fl);
		int gap;
		gap = send_idle_on ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		mode <= m;
		page <= pg;
		usable_flag <= fl;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_replies.push_back(serve_request(m, pg, fl));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_empty_map();
		send_request(MODE_ALLOC, 12'h000, 1'b0);
		send_request(MODE_UNUSED, 12'hFFF, 1'b1);
		send_request(MODE_FREE, 12'h000, 1'b0);
		send_request(MODE_SET_USABLE, 12'h000, 1'b0);
		wait_idle();
	endtask

	// The only usable page sits under the cursor, so the scan must come back empty.
	task automatic test_cursor_page();
		send_request(MODE_SET_USABLE, 12'h000, 1'b1);
		send_request(MODE_ALLOC, 12'hFFF, 1'b1);
		wait_idle();
	endtask

	task automatic test_wrap_around();
		send_request(MODE_SET_USABLE, 12'hFFF, 1'b1);
		send_request(MODE_SET_USABLE, 12'h555, 1'b1);
		send_request(MODE_SET_USABLE, 12'hAAA, 1'b1);
		repeat (5)
			send_request(MODE_ALLOC, 12'h000, 1'b0);
		wait_idle();
	endtask

	task automatic test_free_rules();
		send_request(MODE_FREE, 12'h000, 1'b0);
		send_request(MODE_FREE, 12'h000, 1'b1);
		send_request(MODE_FREE, 12'h001, 1'b0);
		// An allocated page that loses its usable mark stays counted and cannot be freed.
		send_request(MODE_SET_USABLE, 12'hAAA, 1'b0);
		send_request(MODE_ALLOC, 12'h000, 1'b0);
		send_request(MODE_FREE, 12'hAAA, 1'b0);
		send_request(MODE_SET_USABLE, 12'hAAA, 1'b1);
		send_request(MODE_FREE, 12'hAAA, 1'b0);
		send_request(MODE_SET_USABLE, 12'h555, 1'b1);
		wait_idle();
	endtask

	// Fill every usable page, then free the cursor page: counts differ but the
	// scan finds nothing.
	task automatic test_exhausted_scan();
		send_request(MODE_SET_USABLE, 12'h007, 1'b1);
		for (int n = 0; n < 8 && pages_held < pages_usable; n++)
			send_request(MODE_ALLOC, 12'h000, 1'b0);
		send_request(MODE_FREE, last_grant, 1'b0);
		send_request(MODE_ALLOC, 12'h000, 1'b0);
		if (held_pages.size() != 0)
			send_request(MODE_FREE, held_pages[0], 1'b0);
		send_request(MODE_ALLOC, 12'h000, 1'b0);
		wait_idle();
	endtask

	task automatic test_random_traffic(input int count);
		int          roll;
		logic [11:0] base;
		logic [11:0] pg;
		logic [1:0]  m;
		logic        fl;
		base = 12'($urandom);
		for (int n = 0; n < count; n++) begin
			// Work inside a small window of pages so that frees and
			// allocations keep meeting each other; move it now and then.
			if (n % 100 == 99)
				base = 12'($urandom);
			pg = base + 12'($urandom_range(0, 47));
			if ($urandom_range(0, 9) == 0)
				pg = 12'($urandom);
			fl = 1'($urandom);
			roll = $urandom_range(0, 99);
			if (roll < 35) begin
				m = MODE_ALLOC;
			end else if (roll < 60) begin
				m = MODE_FREE;
				if (held_pages.size() != 0 && $urandom_range(0, 99) < 85)
					pg = held_pages[$urandom_range(0, held_pages.size() - 1)];
			end else if (roll < 94) begin
				m = MODE_SET_USABLE;
				fl = ($urandom_range(0, 3) != 0);
			end else begin
				m = MODE_UNUSED;
			end
			send_request(m, pg, fl);
		end
		wait_idle();
	endtask

	task automatic test_back_to_back();
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		test_random_traffic(40);
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
	endtask

	// The reply side holds off long enough for the block to fill and stall requests.
	task automatic test_output_backpressure();
		send_idle_on = 1'b0;
		hold_request = 250;
		for (int n = 0; n < 12; n++) begin
			if (n % 2 == 0)
				send_request(MODE_SET_USABLE, 12'($urandom), 1'b1);
			else
				send_request(MODE_ALLOC, 12'($urandom), 1'($urandom));
		end
		send_idle_on = 1'b1;
		wait_idle();
	endtask

	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			stall_left = recv_idle_on ? pick_gap() : 0;
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_replies.size() == 0) begin
				$error("reply word with no request pending: ok=%0d granted_page=%0d",
					ok, granted_page);
				fail_count++;
			end else begin
				want = pending_replies.pop_front();
				if (ok !== want.ok) begin
					$error("ok: expected %0d, got %0d", want.ok, ok);
					fail_count++;
				end
				if (granted_page !== want.granted_page) begin
					$error("granted_page: expected %0d, got %0d",
						want.granted_page, granted_page);
					fail_count++;
				end
				if (allocated_count !== want.allocated_count) begin
					$error("allocated_count: expected %0d, got %0d",
						want.allocated_count, allocated_count);
					fail_count++;
				end
				if (usable_count !== want.usable_count) begin
					$error("usable_count: expected %0d, got %0d",
						want.usable_count, usable_count);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_map();
		test_cursor_page();
		test_wrap_around();
		test_free_rules();
		test_exhausted_scan();
		test_output_backpressure();
		test_back_to_back();
		test_random_traffic(600);
		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending_replies.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			if (pending_replies.size() != 0)
				$error("%0d reply words never arrived", pending_replies.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[files.f]
hdl/pba_pkg.sv
hdl/pba_map_ram.sv
hdl/pba_seq.sv
hdl/page_bitmap_allocator_top.sv
bench/tb.sv
